// ===== rtl/uid_dedup_cooldown_table_unit_assert.svh =====
// Assertion macros for the identifier dedup table.
`ifndef UID_DEDUP_COOLDOWN_TABLE_UNIT_ASSERT_SVH
`define UID_DEDUP_COOLDOWN_TABLE_UNIT_ASSERT_SVH

// Check cons in the same cycle as ante.
`define UDCT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante.
`define UDCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/udct_pkg.sv =====
package udct_pkg;

  localparam int UID_LO_W = 64;
  localparam int UID_HI_W = 16;
  localparam int UID_RAW_W = UID_LO_W + UID_HI_W;
  localparam int LEN_W = 4;
  localparam int TICK_W = 32;
  localparam int CNT_W = 8;
  localparam int SLOT_W = 8;

  localparam logic [TICK_W-1:0] COOLDOWN_RESET = 32'd5000;
  localparam logic [TICK_W-1:0] FIRST_SEEN_STEP = 32'd1000;

  typedef struct packed {
    logic [UID_LO_W-1:0] uid_low_bytes;
    logic [UID_HI_W-1:0] uid_high_bytes;
    logic [LEN_W-1:0]    uid_length;
    logic [TICK_W-1:0]   now_tick;
  } in_word_t;

  typedef struct packed {
    logic              report;
    logic              is_new;
    logic [TICK_W-1:0] first_tick;
    logic [TICK_W-1:0] seen_tick;
    logic [CNT_W-1:0]  sight_count;
    logic [TICK_W-1:0] unique_total;
  } out_word_t;

  // Scan token handed from cell to cell.
  typedef struct packed {
    logic              live;
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
    logic [TICK_W-1:0] hit_tick;
    logic [CNT_W-1:0]  hit_count;
    logic              has_free;
    logic [SLOT_W-1:0] open_slot;
    logic              has_old;
    logic [SLOT_W-1:0] old_slot;
    logic [TICK_W-1:0] old_tick;
  } scan_tok_t;

  // Entry update broadcast to all cells.
  typedef struct packed {
    logic              en;
    logic              fill;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  len;
    logic [TICK_W-1:0] tick;
    logic [CNT_W-1:0]  count;
  } wr_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } udct_state_t;

endpackage

// ===== rtl/uid_dedup_cooldown_table_unit.sv =====
// One word is in flight at a time: the input stalls outside the idle state.
// A scan token walks the chain of entry cells one cell per cycle, then the
// decide state, held while the result word is stalled, updates the slot.
// Reset (synchronous, rst_n low): all entries invalid, unique count zero,
// cooldown back to 5000 ticks, no result pending.
`include "uid_dedup_cooldown_table_unit_assert.svh"

module uid_dedup_cooldown_table_unit
  import udct_pkg::*;
#(
  parameter int ENTRIES   = 32,
  parameter int UID_BYTES = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_word_t          in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output out_word_t         out_word,
  input  logic              cfg_wr_en,
  input  logic [TICK_W-1:0] cfg_wr_data
);

  localparam int KEY_W = UID_BYTES * 8;

  udct_state_t state_r, state_nxt;

  logic              in_accept;
  logic              fire;
  logic              inject_r;
  logic [KEY_W-1:0]  key_r;
  logic [KEY_W-1:0]  key_nxt;
  logic [LEN_W-1:0]  len_r;
  logic [LEN_W-1:0]  len_nxt;
  logic [TICK_W-1:0] now_r;
  logic [TICK_W-1:0] cooldown_r;
  logic [TICK_W-1:0] unique_r;
  logic [TICK_W-1:0] unique_inc;
  scan_tok_t         tok_fin_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  out_word_t         out_r;
  out_word_t         out_nxt;
  wr_cmd_t           wr_cmd;
  logic [UID_RAW_W-1:0] raw;
  logic [CNT_W-1:0]  cnt_inc;
  logic [TICK_W-1:0] gap;
  logic [TICK_W-1:0] step_back;
  logic [SLOT_W-1:0] miss_slot;
  logic [ENTRIES-1:0] live_vec;

  scan_tok_t tok_w [0:ENTRIES];

  assign in_accept = in_valid && !in_stall;

  // Clamp the length and zero every byte past it before it meets the table.
  assign raw = {in_word.uid_high_bytes, in_word.uid_low_bytes};

  always_comb begin
    len_nxt = (in_word.uid_length > LEN_W'(UID_BYTES)) ? LEN_W'(UID_BYTES)
                                                       : in_word.uid_length;
    key_nxt = '0;
    for (int b = 0; b < UID_BYTES; b++) begin
      if (LEN_W'(b) < len_nxt) begin
        key_nxt[b*8 +: 8] = raw[b*8 +: 8];
      end
    end
  end

  // Start token: empty, made live by the registered accept strobe.
  always_comb begin
    tok_w[0]      = '0;
    tok_w[0].live = inject_r;
  end

  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    udct_cell #(
      .KEY_W (KEY_W),
      .IDX   (k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .key_i    (key_r),
      .len_i    (len_r),
      .tok_i    (tok_w[k]),
      .tok_o    (tok_w[k+1]),
      .wr_i     (wr_cmd),
      .wr_key_i (key_r)
    );
    assign live_vec[k] = tok_w[k+1].live;
  end

  // Next state: scan until the token leaves the last cell, then wait for room.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_accept) state_nxt = ST_SCAN;
      ST_SCAN:   if (tok_w[ENTRIES].live) state_nxt = ST_DECIDE;
      ST_DECIDE: if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Hit and miss arithmetic on the captured token.
  assign cnt_inc    = tok_fin_r.hit_count + CNT_W'(1);
  assign gap        = now_r - tok_fin_r.hit_tick;
  assign step_back  = TICK_W'(cnt_inc) * FIRST_SEEN_STEP;
  assign unique_inc = unique_r + TICK_W'(1);
  assign miss_slot  = tok_fin_r.has_free ? tok_fin_r.open_slot : tok_fin_r.old_slot;

  always_comb begin
    if (tok_fin_r.hit) begin
      out_nxt.report       = (gap >= cooldown_r);
      out_nxt.is_new       = 1'b0;
      out_nxt.first_tick   = now_r - step_back;
      out_nxt.sight_count  = cnt_inc;
      out_nxt.unique_total = unique_r;
    end else begin
      out_nxt.report       = 1'b1;
      out_nxt.is_new       = 1'b1;
      out_nxt.first_tick   = now_r;
      out_nxt.sight_count  = CNT_W'(1);
      out_nxt.unique_total = unique_inc;
    end
    out_nxt.seen_tick = now_r;
  end

  // Outputs of the control: stall, entry update and result load.
  always_comb begin
    in_stall = 1'b1;
    fire     = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_stall = 1'b0;
      ST_SCAN:   fire = 1'b0;
      ST_DECIDE: fire = !out_valid_r || !out_stall;
      default:   in_stall = 1'b1;
    endcase
  end

  always_comb begin
    wr_cmd.en    = fire;
    wr_cmd.fill  = !tok_fin_r.hit;
    wr_cmd.slot  = tok_fin_r.hit ? tok_fin_r.hit_slot : miss_slot;
    wr_cmd.len   = len_r;
    wr_cmd.tick  = now_r;
    wr_cmd.count = tok_fin_r.hit ? cnt_inc : CNT_W'(1);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      inject_r    <= 1'b0;
      out_valid_r <= 1'b0;
      cooldown_r  <= COOLDOWN_RESET;
      unique_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      inject_r    <= in_accept;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cooldown_r <= cfg_wr_data;
      end
      // Count every insertion; wrap at 32 bits.
      if (fire && !tok_fin_r.hit) begin
        unique_r <= unique_inc;
      end
    end
  end

  // Payload: hold the masked word during the scan, capture the final token.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      key_r <= key_nxt;
      len_r <= len_nxt;
      now_r <= in_word.now_tick;
    end
    if (state_r == ST_SCAN && tok_w[ENTRIES].live) begin
      tok_fin_r <= tok_w[ENTRIES];
    end
    if (fire) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  `UDCT_ASSERT_NOW(a_one_token, 1'b1, $onehot0(live_vec),
                   "more than one scan token in the chain")
  `UDCT_ASSERT_NOW(a_token_in_scan, tok_w[ENTRIES].live, state_r == ST_SCAN,
                   "scan token left the chain outside a scan")
  `UDCT_ASSERT_NEXT(a_accept_scan, in_accept, state_r == ST_SCAN && inject_r,
                    "accepted word did not start a scan")
  `UDCT_ASSERT_NEXT(a_fire_result, fire, out_valid_r && state_r == ST_IDLE,
                    "entry update without a result word")

endmodule

// ===== rtl/udct_cell.sv =====
module udct_cell
  import udct_pkg::*;
#(
  parameter int KEY_W = 80,
  parameter int IDX   = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [KEY_W-1:0] key_i,
  input  logic [LEN_W-1:0] len_i,
  input  scan_tok_t        tok_i,
  output scan_tok_t        tok_o,
  input  wr_cmd_t          wr_i,
  input  logic [KEY_W-1:0] wr_key_i
);

  localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);

  logic              valid_r;
  logic [LEN_W-1:0]  len_r;
  logic [KEY_W-1:0]  key_r;
  logic [TICK_W-1:0] tick_r;
  logic [CNT_W-1:0]  count_r;
  scan_tok_t         tok_r;
  scan_tok_t         tok_nxt;
  logic              match;
  logic              sel;

  assign match = valid_r && (len_r == len_i) && (key_r == key_i);
  assign sel   = wr_i.en && (wr_i.slot == MY_SLOT);

  always_comb begin
    tok_nxt = tok_i;
    if (!tok_i.hit && match) begin
      tok_nxt.hit       = 1'b1;
      tok_nxt.hit_slot  = MY_SLOT;
      tok_nxt.hit_tick  = tick_r;
      tok_nxt.hit_count = count_r;
    end
    if (!tok_i.has_free && !valid_r) begin
      tok_nxt.has_free  = 1'b1;
      tok_nxt.open_slot = MY_SLOT;
    end
    // Strictly older only, so the lower slot keeps ties.
    if (!tok_i.has_old || (tick_r < tok_i.old_tick)) begin
      tok_nxt.has_old  = 1'b1;
      tok_nxt.old_slot = MY_SLOT;
      tok_nxt.old_tick = tick_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
      if (sel && wr_i.fill) begin
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      tick_r  <= wr_i.tick;
      count_r <= wr_i.count;
      if (wr_i.fill) begin
        len_r <= wr_i.len;
        key_r <= wr_key_i;
      end
    end
  end

  assign tok_o = tok_r;

endmodule

// ===== sim/uid_dedup_cooldown_table_unit_tb.sv =====
`timescale 1ns / 100ps

module uid_dedup_cooldown_table_unit_tb;
  import udct_pkg::*;

  localparam int TABLE_ROWS  = 32;
  localparam int UID_MAX     = 10;
  localparam int POOL_SIZE   = 40;        // more identifiers than rows, so rows get evicted
  localparam int CYCLE_LIMIT = 1_000_000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;
  logic      cfg_wr_en = 1'b0;
  logic [TICK_W-1:0] cfg_wr_data = '0;

  uid_dedup_cooldown_table_unit #(
    .ENTRIES  (TABLE_ROWS),
    .UID_BYTES(UID_MAX)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the sighting table: rows, unique count and the cooldown register.
  // Updated in acceptance order, so it always reflects what the block should
  // hold right after the last accepted word.
  // ---------------------------------------------------------------------------
  logic [UID_LO_W-1:0] row_lo   [TABLE_ROWS];
  logic [UID_HI_W-1:0] row_hi   [TABLE_ROWS];
  logic [LEN_W-1:0]    row_len  [TABLE_ROWS];
  logic [TICK_W-1:0]   row_tick [TABLE_ROWS];
  logic [CNT_W-1:0]    row_count[TABLE_ROWS];
  logic                row_used [TABLE_ROWS];
  logic [TICK_W-1:0]   inserted_total;
  logic [TICK_W-1:0]   cooldown_cfg;

  in_word_t  pending_words[$];    // words waiting for the driver
  out_word_t sighting_results[$]; // expected result words, oldest first

  int mismatch_count = 0;
  int words_in = 0;
  int cycle_count = 0;

  // Sender and receiver knobs, changed only between phases.
  int gap_max = 0;
  int stall_pct = 0;

  // Stimulus generator state.
  logic [UID_LO_W-1:0] pool_lo [POOL_SIZE];
  logic [UID_HI_W-1:0] pool_hi [POOL_SIZE];
  logic [LEN_W-1:0]    pool_len[POOL_SIZE];
  logic [TICK_W-1:0]   clock_ms = '0;
  int                  last_pick = -1;

  // Look the identifier up, then either refresh its row or insert it into the
  // first free row or the stalest one (lowest index on equal ticks).
  function automatic out_word_t predict_sighting(in_word_t w);
    out_word_t r;
    logic [LEN_W-1:0]    len;
    logic [UID_LO_W-1:0] lo;
    logic [UID_HI_W-1:0] hi;
    logic [TICK_W-1:0]   gap;
    logic [CNT_W-1:0]    cnt;
    int slot;
    int oldest;
    // Clamp oversize lengths and zero every byte past the length.
    len = (w.uid_length > UID_MAX) ? LEN_W'(UID_MAX) : w.uid_length;
    lo = w.uid_low_bytes;
    hi = w.uid_high_bytes;
    for (int b = 0; b < 8; b++)
      if (b >= len) lo[8*b +: 8] = 8'h00;
    for (int b = 0; b < 2; b++)
      if (b + 8 >= len) hi[8*b +: 8] = 8'h00;

    slot = -1;
    for (int i = 0; i < TABLE_ROWS; i++)
      if (slot < 0 && row_used[i] && row_len[i] == len && row_lo[i] == lo && row_hi[i] == hi)
        slot = i;

    r = '0;
    r.seen_tick = w.now_tick;
    if (slot >= 0) begin
      gap = w.now_tick - row_tick[slot];
      cnt = row_count[slot] + 8'd1;
      row_tick[slot]  = w.now_tick;
      row_count[slot] = cnt;
      r.report       = (gap >= cooldown_cfg);
      r.is_new       = 1'b0;
      r.first_tick   = w.now_tick - {24'd0, cnt} * FIRST_SEEN_STEP;
      r.sight_count  = cnt;
      r.unique_total = inserted_total;
    end else begin
      oldest = 0;
      for (int i = 0; i < TABLE_ROWS; i++) begin
        if (slot < 0 && !row_used[i]) slot = i;
        if (row_tick[i] < row_tick[oldest]) oldest = i;
      end
      if (slot < 0) slot = oldest;
      row_lo[slot]    = lo;
      row_hi[slot]    = hi;
      row_len[slot]   = len;
      row_tick[slot]  = w.now_tick;
      row_count[slot] = 8'd1;
      row_used[slot]  = 1'b1;
      inserted_total  = inserted_total + 32'd1;
      r.report       = 1'b1;
      r.is_new       = 1'b1;
      r.first_tick   = w.now_tick;
      r.sight_count  = 8'd1;
      r.unique_total = inserted_total;
    end
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    mismatch_count++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present the head of pending_words, hold it while stalled, pop and
  // predict on acceptance. Bursts of random length alternate with random gaps.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin : drive_words
    logic taken;
    taken = in_valid && !in_stall;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (taken) begin
        sighting_results.push_back(predict_sighting(in_word));
        void'(pending_words.pop_front());
        words_in <= words_in + 1;
      end
      if (in_valid && !taken) begin
        // hold the stalled word
      end else if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_words.size() != 0) begin
        in_valid <= 1'b1;
        in_word  <= pending_words[0];
        // At the end of a burst, draw the next gap and burst length.
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left   <= $urandom_range(0, gap_max);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Long hold-off: twice in the run, keep the result side blocked long enough
  // that the block fills up and stalls its input while the sender keeps going.
  // ---------------------------------------------------------------------------
  int hold_left = 0;
  int hold_idx = 0;

  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_idx < 2 && words_in >= (hold_idx == 0 ? 650 : 1250)) begin
      hold_left <= 500;
      hold_idx  <= hold_idx + 1;
    end
  end

  // Receiver: stall in random runs, at a rate set per phase.
  int stall_run = 0;

  always @(posedge clk) begin
    if (stall_run != 0) begin
      stall_run <= stall_run - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_run <= $urandom_range(0, 15);
      out_stall <= 1'b1;
    end else begin
      out_stall <= (hold_left != 0);
    end
  end

  // Monitor: compare each accepted result word with the oldest expectation.
  always @(posedge clk) begin : check_words
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (sighting_results.size() == 0) begin
        flag_mismatch("result word with nothing expected");
      end else begin
        want = sighting_results.pop_front();
        check_field("report", out_word.report, want.report);
        check_field("is_new", out_word.is_new, want.is_new);
        check_field("first_tick", out_word.first_tick, want.first_tick);
        check_field("seen_tick", out_word.seen_tick, want.seen_tick);
        check_field("sight_count", out_word.sight_count, want.sight_count);
        check_field("unique_total", out_word.unique_total, want.unique_total);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycle_count, sighting_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_word(logic [63:0] lo, logic [15:0] hi, logic [3:0] len, logic [31:0] tick);
    in_word_t w;
    w.uid_low_bytes  = lo;
    w.uid_high_bytes = hi;
    w.uid_length     = len;
    w.now_tick       = tick;
    pending_words.push_back(w);
  endtask

  // Sight pool identifier k: keep its significant bytes, randomize the rest,
  // and vary the length among equivalent oversize values.
  task automatic push_pool_sighting(int k, logic [31:0] tick);
    logic [63:0] lo;
    logic [15:0] hi;
    logic [3:0]  len;
    int eff;
    eff = (pool_len[k] > UID_MAX) ? UID_MAX : pool_len[k];
    lo = {$urandom, $urandom};
    hi = 16'($urandom);
    for (int b = 0; b < 8; b++)
      if (b < eff) lo[8*b +: 8] = pool_lo[k][8*b +: 8];
    for (int b = 0; b < 2; b++)
      if (b + 8 < eff) hi[8*b +: 8] = pool_hi[k][8*b +: 8];
    len = (pool_len[k] >= UID_MAX) ? 4'($urandom_range(UID_MAX, 15)) : pool_len[k];
    push_word(lo, hi, len, tick);
    last_pick = k;
  endtask

  task automatic new_pool_entry(int k);
    pool_lo[k]  = {$urandom, $urandom};
    pool_hi[k]  = 16'($urandom);
    pool_len[k] = 4'($urandom_range(0, 15));
  endtask

  // Mostly re-sightings from the pool with a drifting tick; some repeats land
  // exactly on or one short of the cooldown, some brand-new identifiers, and
  // some wild tick jumps.
  task automatic queue_random(int n);
    int pick;
    int k;
    int sel;
    logic [31:0] tick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15 && last_pick >= 0) begin
        k = last_pick;
        tick = clock_ms + cooldown_cfg - 32'($urandom_range(0, 1));
      end else begin
        k = $urandom_range(0, POOL_SIZE - 1);
        if (pick < 30) new_pool_entry(k);
        sel = $urandom_range(0, 99);
        if (sel < 10) tick = clock_ms;
        else if (sel < 70) tick = clock_ms + $urandom_range(0, 6000);
        else if (sel < 90) tick = clock_ms + $urandom_range(0, 200);
        else tick = $urandom;
      end
      clock_ms = tick;
      push_pool_sighting(k, tick);
    end
  endtask

  // Hammer one identifier so its count runs past 255 and wraps.
  task automatic queue_repeats(int n);
    int k;
    k = $urandom_range(0, POOL_SIZE - 1);
    for (int i = 0; i < n; i++) begin
      clock_ms = clock_ms + $urandom_range(0, 3000);
      push_pool_sighting(k, clock_ms);
    end
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || sighting_results.size() != 0 || in_valid)
      @(negedge clk);
  endtask

  // Write the cooldown register; only called while the block is idle.
  task automatic write_cooldown(logic [31:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    cooldown_cfg = value;
    @(negedge clk);
  endtask

  task automatic run_phase(logic [31:0] cooldown, int gaps, int stalls, int n);
    write_cooldown(cooldown);
    gap_max   = gaps;
    stall_pct = stalls;
    queue_random(n);
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < TABLE_ROWS; i++) begin
      row_lo[i]    = '0;
      row_hi[i]    = '0;
      row_len[i]   = '0;
      row_tick[i]  = '0;
      row_count[i] = '0;
      row_used[i]  = 1'b0;
    end
    inserted_total = '0;
    cooldown_cfg   = COOLDOWN_RESET;
    for (int k = 0; k < POOL_SIZE; k++) new_pool_entry(k);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words at the reset cooldown, no idling on either side.
    push_word(64'h0, 16'h0, 4'd0, 32'd0);                          // empty id, new
    push_word(64'hDEAD_BEEF_0123_4567, 16'hFFFF, 4'd0, 32'd4999);  // one tick short
    push_word(64'h5555_AAAA_5555_AAAA, 16'h0F0F, 4'd0, 32'd9999);  // exactly on cooldown
    push_word('1, '1, 4'd10, 32'hFFFF_FFFF);                       // full length, new
    push_word('1, '1, 4'd15, 32'h0000_1387);                       // clamped, wrapped gap
    push_word('1, '1, 4'd11, 32'h0000_1388);                       // clamped, gap of one
    push_word(64'h0123_4567_89AB_CDEF, 16'h5555, 4'd3, 32'd100);   // short id, new
    push_word(64'hFEDC_BA98_76AB_CDEF, 16'hAAAA, 4'd3, 32'd200);   // same bytes, junk past
    push_word(64'h0000_0000_00AB_CDEF, 16'h0000, 4'd4, 32'd300);   // same bytes, longer
    push_word(64'h0, 16'h0, 4'd1, 32'd400);                        // one zero byte vs empty
    push_word('1, 16'h1234, 4'd8, 32'd500);                        // high bytes ignored
    push_word('1, 16'h5634, 4'd9, 32'd600);
    push_word('1, 16'hAB34, 4'd9, 32'd700);                        // hit on byte 8 only
    push_word('1, 16'h0034, 4'd10, 32'd800);
    push_word(64'h8000_0000_0000_0000, 16'h8000, 4'd10, 32'h8000_0000);
    push_word(64'h8000_0000_0000_0000, 16'h8000, 4'd10, 32'h8000_0000); // zero gap
    push_word(64'h0, 16'h0, 4'd0, 32'h7FFF_FFFF);                  // long gap on empty id
    wait_drained();

    // Zero cooldown; finish with a hammer run that wraps a count.
    run_phase(32'd0, 6, 30, 300);
    queue_repeats(260);
    wait_drained();
    run_phase(32'hFFFF_FFFF, 20, 50, 280);
    run_phase(32'($urandom_range(1, 8000)), 0, 0, 300);
    run_phase(32'd1, 3, 70, 250);
    run_phase(COOLDOWN_RESET, 10, 20, 310);

    // Let any stray result word show up before judging.
    repeat (2 * TABLE_ROWS + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
